@@ design/sgs_pkg.sv @@
// Shared constants and types of the Savitzky-Golay smoother.
// No dependencies; imported by every module of the block.
package sgs_pkg;
  localparam int MAX_WIN      = 15;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;
  localparam int FRAC_BITS    = 14;
  localparam int IDX_W        = $clog2(MAX_WIN);
  localparam int CNT_W        = $clog2(MAX_WIN + 1);
  localparam int TAB_DEPTH    = MAX_WIN * MAX_WIN;
  localparam int TAB_AW       = $clog2(TAB_DEPTH);
  localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W        = PROD_W + CNT_W;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]        acc_t;

  // control handed to the multiply-accumulate alongside its operands
  typedef struct packed {
    logic clr;
    logic fire;
  } mac_ctl_t;

  function automatic sample_t round_sat(input acc_t acc);
    acc_t r;
    acc_t q;
    acc_t hi;
    acc_t lo;
    hi = acc_t'((ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1));
    lo = ~hi;
    r  = acc + acc_t'(ACC_W'(1) <<< (FRAC_BITS - 1));
    q  = r >>> FRAC_BITS;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[SAMPLE_WIDTH-1:0];
  endfunction
endpackage

@@ design/sgs_tap_cell.sv @@
// One cell of the sample chain: holds one window sample and one head sample.
// Depends on sgs_pkg.
module sgs_tap_cell import sgs_pkg::*; (
  input  logic    clk,
  input  logic    shift_en,
  input  sample_t shift_in,
  input  logic    head_we,
  input  sample_t head_in,
  input  logic    rot_en,
  input  sample_t rot_in,
  output sample_t win_q,
  output sample_t head_q
);
  sample_t win_r;
  sample_t head_r;

  always_ff @(posedge clk) begin
    if (shift_en) win_r <= shift_in;
    if (head_we) head_r <= head_in;
    else if (rot_en) head_r <= rot_in;
  end

  assign win_q  = win_r;
  assign head_q = head_r;
endmodule

@@ design/sgs_mac.sv @@
// Shared multiply-accumulate: registered product, then accumulate, then round.
// Depends on sgs_pkg.
module sgs_mac import sgs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  mac_ctl_t ctl,
  input  sample_t  smp,
  input  coef_t    coef,
  output logic     done,
  output sample_t  result
);
  logic signed [PROD_W-1:0] prod_r;
  acc_t     acc_r;
  mac_ctl_t ctl_r;
  logic     v_r;
  logic     done_r;
  sample_t  res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v_r    <= en;
      done_r <= v_r && ctl_r.fire;
    end
    prod_r <= PROD_W'(smp * coef);
    ctl_r  <= ctl;
    if (v_r) begin
      if (ctl_r.clr) acc_r <= acc_t'(prod_r);
      else acc_r <= acc_r + acc_t'(prod_r);
    end
    if (v_r && ctl_r.fire) begin
      if (ctl_r.clr) res_r <= round_sat(acc_t'(prod_r));
      else res_r <= round_sat(acc_r + acc_t'(prod_r));
    end
  end

  assign done   = done_r;
  assign result = res_r;
endmodule

@@ design/savitzky_golay_smoother_unit.sv @@
// Top level of the Savitzky-Golay smoother: sequencer, coefficient memory,
// tap chain and output register. Depends on sgs_pkg, sgs_tap_cell, sgs_mac.
//
//  channel | ports                                         | dir
//  in      | in_valid in_stall in_opcode in_coef_row       | in
//          | in_coef_col in_coef_value in_sample in_last   |
//  out     | out_valid out_stall out_value out_last_out    | out
//          | out_too_short                                 |
//  cfg     | cfg_we cfg_data                               | in
//
// A sample shifts into the chain, then each result it yields takes one pass:
// n taps through the shared multiplier, the pipeline drain, the output state
// and the step state. A middle sample yields one pass, the head k+1 passes
// when it completes, and the series n-k passes when it ends.
// Synchronous active-low reset clears control and sets n to 5; the
// coefficient table and sample chain are not cleared. A stalled output holds
// the block in its current pass.
module savitzky_golay_smoother_unit import sgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [3:0]            in_coef_row,
  input  logic [3:0]            in_coef_col,
  input  coef_t                 in_coef_value,
  input  sample_t               in_sample,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sample_t               out_value,
  output logic                  out_last_out,
  output logic                  out_too_short,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_data
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_NEXT = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_MID  = 2'd1,
    PH_TAIL = 2'd2
  } phase_t;

  state_t st_r, st_nxt;
  phase_t ph_r;
  logic [3:0]     wlen_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] col_r;
  logic           last_r;
  logic           ov_r;
  sample_t        ovalue_r;
  logic           olast_r;
  logic           oshort_r;

  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] k_eff;
  always_comb begin
    if (wlen_r < 4'd3) n_eff = CNT_W'(3);
    else if (32'(wlen_r) > MAX_WIN) n_eff = CNT_W'(MAX_WIN);
    else n_eff = CNT_W'(wlen_r);
    k_eff = IDX_W'(n_eff >> 1);
  end

  logic accept;
  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // coefficient memory
  coef_t tab_mem [TAB_DEPTH];
  coef_t coef_rd_r;
  logic [TAB_AW-1:0] rd_addr;
  logic tab_we;
  assign tab_we = accept && !in_opcode && 32'(in_coef_row) < MAX_WIN &&
                  32'(in_coef_col) < MAX_WIN;
  assign rd_addr = TAB_AW'(32'(row_r) * MAX_WIN + 32'(col_r));
  always_ff @(posedge clk) begin
    if (tab_we)
      tab_mem[TAB_AW'(32'(in_coef_row) * MAX_WIN + 32'(in_coef_col))] <= in_coef_value;
    coef_rd_r <= tab_mem[rd_addr];
  end

  // tap chain: window shifts on a sample and rotates in a mid or tail pass; head rotates in a head pass
  logic samp_acc;
  assign samp_acc = accept && in_opcode;
  logic    run;
  assign run = (st_r == ST_RUN);
  logic    win_rot;   // circular shift of window by one per tap
  logic    head_rot;
  sample_t win_q  [MAX_WIN];
  sample_t head_q [MAX_WIN];
  sample_t shift_in [MAX_WIN];
  sample_t rot_in   [MAX_WIN];
  logic    head_we  [MAX_WIN];
  logic [CNT_W-1:0] wtop;

  // during a mid pass window taps rotate toward cell 0 over cells 0..n-1;
  // during a tail pass they rotate the other way so the oldest comes first
  assign win_rot  = run && ph_r != PH_HEAD;
  assign head_rot = run && ph_r == PH_HEAD;
  assign wtop     = n_eff - CNT_W'(1);

  genvar g;
  generate
    for (g = 0; g < MAX_WIN; g++) begin : g_cell
      always_comb begin
        if (samp_acc) begin
          shift_in[g] = (g == 0) ? in_sample : win_q[(g == 0) ? 0 : g - 1];
        end else if (ph_r == PH_TAIL) begin
          // toward higher index, cell 0 gets top
          if (g == 0) shift_in[g] = win_q[wtop[IDX_W-1:0]];
          else shift_in[g] = win_q[(g == 0) ? 0 : g - 1];
        end else begin
          if (CNT_W'(g) == wtop) shift_in[g] = win_q[0];
          else shift_in[g] = win_q[(g == MAX_WIN - 1) ? g : g + 1];
        end
        if (CNT_W'(g) == wtop) rot_in[g] = head_q[0];
        else rot_in[g] = head_q[(g == MAX_WIN - 1) ? g : g + 1];
        head_we[g] = samp_acc && cnt_r < n_eff && cnt_r == CNT_W'(g);
      end
      sgs_tap_cell u_cell (
        .clk      (clk),
        .shift_en (samp_acc || (win_rot && (ph_r == PH_TAIL || CNT_W'(g) <= wtop))),
        .shift_in (shift_in[g]),
        .head_we  (head_we[g]),
        .head_in  (in_sample),
        .rot_en   (head_rot && CNT_W'(g) <= wtop),
        .rot_in   (rot_in[g]),
        .win_q    (win_q[g]),
        .head_q   (head_q[g])
      );
    end
  endgenerate

  // tail rotation is not confined to cells 0..n-1: cells above wtop shift
  // too, but their contents are never read by a pass, so that is harmless

  // sample operand aligns with the registered coefficient read
  sample_t  smp_r;
  logic     mac_en_r;
  mac_ctl_t ctl_r;
  logic     mac_done;
  sample_t  mac_res;
  always_ff @(posedge clk) begin
    smp_r <= (ph_r == PH_HEAD) ? head_q[0] :
             (ph_r == PH_TAIL) ? win_q[wtop[IDX_W-1:0]] : win_q[0];
    ctl_r.clr  <= (col_r == '0);
    ctl_r.fire <= (CNT_W'(col_r) == wtop);
    if (!rst_n) mac_en_r <= 1'b0;
    else mac_en_r <= run;
  end

  sgs_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (mac_en_r),
    .ctl    (ctl_r),
    .smp    (smp_r),
    .coef   (coef_rd_r),
    .done   (mac_done),
    .result (mac_res)
  );

  logic [CNT_W-1:0] cnt_new;
  assign cnt_new = (cnt_r >= n_eff) ? n_eff : cnt_r + CNT_W'(1);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (samp_acc) begin
        if (in_last && cnt_new < n_eff) st_nxt = ST_OUT;
        else if (cnt_new == n_eff) st_nxt = ST_RUN;
      end
      ST_RUN:  if (CNT_W'(col_r) == wtop) st_nxt = ST_WAIT;
      ST_WAIT: if (mac_done) st_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) st_nxt = ST_NEXT;
      ST_NEXT: st_nxt = (ph_r == PH_MID && !last_r) || oshort_r ||
                        (ph_r == PH_TAIL && 32'(row_r) + 1 >= 32'(n_eff)) ||
                        (ph_r == PH_MID && k_eff + 1 >= IDX_W'(n_eff)) ?
                        ST_IDLE : ST_RUN;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      wlen_r <= 4'd5;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) wlen_r <= cfg_data;
      ov_r <= (st_nxt == ST_OUT);
      // drop the count at the end of every series
      if (samp_acc) cnt_r <= in_last ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: if (samp_acc) begin
        last_r   <= in_last;
        col_r    <= '0;
        oshort_r <= in_last && cnt_new < n_eff;
        olast_r  <= 1'b1;
        ovalue_r <= '0;
        if (cnt_r < n_eff && cnt_new == n_eff && k_eff != '0) begin
          ph_r  <= PH_HEAD;
          row_r <= '0;
        end else begin
          ph_r  <= PH_MID;
          row_r <= k_eff;
        end
      end
      ST_RUN: col_r <= (CNT_W'(col_r) == wtop) ? '0 : col_r + IDX_W'(1);
      ST_WAIT: if (mac_done) begin
        ovalue_r <= mac_res;
        olast_r  <= (ph_r == PH_MID && last_r && k_eff + 1 >= IDX_W'(n_eff)) ||
                    (ph_r == PH_TAIL && 32'(row_r) + 1 >= 32'(n_eff));
      end
      ST_NEXT: begin
        col_r <= '0;
        if (ph_r == PH_HEAD) begin
          if (row_r + IDX_W'(1) == k_eff) ph_r <= PH_MID;
          row_r <= row_r + IDX_W'(1);
        end else if (ph_r == PH_MID) begin
          ph_r  <= PH_TAIL;
          row_r <= k_eff + IDX_W'(1);
        end else begin
          row_r <= row_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = ov_r;
  assign out_value     = ovalue_r;
  assign out_last_out  = olast_r;
  assign out_too_short = oshort_r;
endmodule
